// File: rtl/m4inv_pkg.sv
// ----------------------------------------------------------------------------
// m4inv_pkg
// Shared types and constants for the 4x4 fixed-point matrix inverter.
// ----------------------------------------------------------------------------
package m4inv_pkg;

    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam logic [3:0] LAST_INDEX = 4'd15;

    // multiplicand source for the shared serial multiplier
    typedef enum logic [1:0] {
        MC_MAT = 2'd0,
        MC_M2  = 2'd1,
        MC_COF = 2'd2
    } mc_sel_t;

    // what to do with a finished product
    typedef enum logic [2:0] {
        ACC_NONE    = 3'd0,
        ACC_M2_SET  = 3'd1,
        ACC_M2_SUB  = 3'd2,
        ACC_COF_SET = 3'd3,
        ACC_COF_ADD = 3'd4,
        ACC_COF_SUB = 3'd5,
        ACC_DET_SET = 3'd6,
        ACC_DET_ADD = 3'd7
    } acc_op_t;

    typedef struct packed {
        logic       mat_we;
        logic [3:0] mat_waddr;
        logic [3:0] mat_raddr;
        logic       a_load;
        logic       mul_start;
        mc_sel_t    mc_sel;
        logic       mul_step;
        logic       mul_last;
        acc_op_t    acc_op;
        logic       cof_we;
        logic       cof_neg;
        logic [3:0] cof_addr;
        logic       div_init;
        logic       div_step;
        logic       res_we;
        logic [3:0] res_addr;
        logic       flag_clear;
    } m4inv_cmd_t;

    typedef struct packed {
        logic det_zero;
    } m4inv_status_t;

    // i-th index of {0,1,2,3} with excl removed
    function automatic logic [1:0] skip_idx(input logic [1:0] excl, input logic [1:0] i);
        logic [1:0] r;
        r = (i < excl) ? i : i + 2'd1;
        return r;
    endfunction

endpackage

// File: rtl/m4inv_dpath.sv
// ----------------------------------------------------------------------------
// m4inv_dpath
// Element store, serial multiplier with accumulators, cofactor store,
// restoring divider with rounding and saturation, and result store.
// ----------------------------------------------------------------------------
module m4inv_dpath #(
    parameter int WORD_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  m4inv_pkg::m4inv_cmd_t          cmd,
    input  logic [WORD_WIDTH-1:0]          in_data,
    output m4inv_pkg::m4inv_status_t       status,
    output logic [WORD_WIDTH-1:0]          res_data,
    output logic                           res_flag
);
    import m4inv_pkg::*;

    localparam int PW = 4*WORD_WIDTH + 6;
    localparam int NW = PW + 2*FRAC_BITS + 1;
    localparam int CW = NW + WORD_WIDTH + 2;
    localparam int QW = WORD_WIDTH + 2;

    logic [WORD_WIDTH-1:0] mat_mem [16];
    logic [WORD_WIDTH-1:0] mat_rd_reg;
    logic [WORD_WIDTH-1:0] a_reg;

    logic signed [PW-1:0]  cof_mem [16];
    logic signed [PW-1:0]  cof_rd_reg;

    logic signed [PW-1:0]  mc_reg;
    logic [WORD_WIDTH-1:0] mp_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [PW-1:0]  m2_reg;
    logic signed [PW-1:0]  cof_reg;
    logic signed [PW-1:0]  det_reg;

    logic [PW-1:0]         r_reg;
    logic [QW-1:0]         nl_reg;
    logic [QW-1:0]         q_reg;
    logic                  ovf_reg;
    logic                  csign_reg;

    logic [WORD_WIDTH-1:0] res_mem [16];
    logic [WORD_WIDTH-1:0] res_rd_reg;
    logic                  flag_reg;

    logic signed [PW-1:0]  mc_next;
    logic [PW-1:0]         dmag;
    logic [PW-1:0]         cmag;
    logic [NW-1:0]         n2;
    logic [PW:0]           rs;
    logic                  ge;
    logic [QW-1:0]         qr;
    logic                  neg;
    logic [QW-1:0]         poslim;
    logic [QW-1:0]         neglim;
    logic                  sat;
    logic [WORD_WIDTH-1:0] val;
    logic [QW-1:0]         qneg;

    // element store
    always_ff @(posedge clk)
    begin
        if (cmd.mat_we)
        begin
            mat_mem[cmd.mat_waddr] <= in_data;
        end
        mat_rd_reg <= mat_mem[cmd.mat_raddr];
        if (cmd.a_load)
        begin
            a_reg <= mat_rd_reg;
        end
    end

    // cofactor store, sign applied on write
    always_ff @(posedge clk)
    begin
        if (cmd.cof_we)
        begin
            cof_mem[cmd.cof_addr] <= cmd.cof_neg ? -cof_reg : cof_reg;
        end
        cof_rd_reg <= cof_mem[cmd.cof_addr];
    end

    always_comb
    begin
        case (cmd.mc_sel)
            MC_MAT:  mc_next = {{(PW-WORD_WIDTH){a_reg[WORD_WIDTH-1]}}, a_reg};
            MC_M2:   mc_next = m2_reg;
            MC_COF:  mc_next = cof_rd_reg;
            default: mc_next = '0;
        endcase
    end

    // shift-add multiplier, one multiplier bit per cycle; sign bit weighs negative
    always_ff @(posedge clk)
    begin
        if (cmd.mul_start)
        begin
            mc_reg   <= mc_next;
            mp_reg   <= mat_rd_reg;
            prod_reg <= '0;
        end
        else if (cmd.mul_step)
        begin
            if (mp_reg[0])
            begin
                prod_reg <= cmd.mul_last ? prod_reg - mc_reg : prod_reg + mc_reg;
            end
            mc_reg <= mc_reg <<< 1;
            mp_reg <= mp_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.acc_op)
            ACC_M2_SET:  m2_reg  <= prod_reg;
            ACC_M2_SUB:  m2_reg  <= m2_reg - prod_reg;
            ACC_COF_SET: cof_reg <= prod_reg;
            ACC_COF_ADD: cof_reg <= cof_reg + prod_reg;
            ACC_COF_SUB: cof_reg <= cof_reg - prod_reg;
            ACC_DET_SET: det_reg <= prod_reg;
            ACC_DET_ADD: det_reg <= det_reg + prod_reg;
            default:     ;
        endcase
    end

    assign status.det_zero = (det_reg == '0);

    // divider: quotient of 2N/D with QW bits, N = |cof| << 2*FRAC_BITS
    always_comb
    begin
        dmag = det_reg[PW-1] ? PW'(-det_reg) : PW'(det_reg);
        cmag = cof_rd_reg[PW-1] ? PW'(-cof_rd_reg) : PW'(cof_rd_reg);
        n2   = NW'(cmag) << (2*FRAC_BITS + 1);
        rs   = {r_reg, nl_reg[QW-1]};
        ge   = (rs >= {1'b0, dmag});
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            ovf_reg   <= (CW'(n2) >= (CW'(dmag) << QW));
            r_reg     <= PW'(n2 >> QW);
            nl_reg    <= n2[QW-1:0];
            q_reg     <= '0;
            csign_reg <= cof_rd_reg[PW-1];
        end
        else if (cmd.div_step)
        begin
            r_reg  <= ge ? PW'(rs - {1'b0, dmag}) : PW'(rs);
            nl_reg <= nl_reg << 1;
            q_reg  <= {q_reg[QW-2:0], ge};
        end
    end

    // round half away, apply sign, saturate; a zero determinant gives zero
    always_comb
    begin
        qr     = QW'(({1'b0, q_reg} + (QW+1)'(1)) >> 1);
        poslim = QW'((QW'(1) << (WORD_WIDTH-1)) - QW'(1));
        neglim = QW'(QW'(1) << (WORD_WIDTH-1));
        neg    = (csign_reg != det_reg[PW-1]) && (ovf_reg || (qr != '0));
        sat    = 1'b0;
        qneg   = QW'(-qr);
        val    = neg ? qneg[WORD_WIDTH-1:0] : qr[WORD_WIDTH-1:0];
        if (status.det_zero)
        begin
            sat = 1'b1;
            val = '0;
        end
        else if (ovf_reg || (neg && (qr > neglim)) || (!neg && (qr > poslim)))
        begin
            sat = 1'b1;
            val = neg ? {1'b1, {(WORD_WIDTH-1){1'b0}}} : {1'b0, {(WORD_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_we)
        begin
            res_mem[cmd.res_addr] <= val;
        end
        res_rd_reg <= res_mem[cmd.res_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
        end
        else if (cmd.flag_clear)
        begin
            flag_reg <= 1'b0;
        end
        else if (cmd.res_we && sat)
        begin
            flag_reg <= 1'b1;
        end
    end

    assign res_data = res_rd_reg;
    assign res_flag = flag_reg;

endmodule

// File: rtl/m4inv_ctrl.sv
// ----------------------------------------------------------------------------
// m4inv_ctrl
// Sequencer: loads elements, walks the cofactor, determinant, divide and
// output phases, and drives the datapath by command word.
// ----------------------------------------------------------------------------
module m4inv_ctrl #(
    parameter int WORD_WIDTH = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [3:0]                  out_index,
    output logic                        out_last,
    output m4inv_pkg::m4inv_cmd_t       cmd,
    input  m4inv_pkg::m4inv_status_t    status
);
    import m4inv_pkg::*;

    localparam int QW = WORD_WIDTH + 2;
    localparam int SW = $clog2(QW + 1);

    typedef enum logic [12:0] {
        ST_LOAD      = 13'b0000000000001,
        ST_FETCH_A   = 13'b0000000000010,
        ST_FETCH_B   = 13'b0000000000100,
        ST_MUL_START = 13'b0000000001000,
        ST_MUL_RUN   = 13'b0000000010000,
        ST_ACC       = 13'b0000000100000,
        ST_COF_WR    = 13'b0000001000000,
        ST_DIV_RD    = 13'b0000010000000,
        ST_DIV_INIT  = 13'b0000100000000,
        ST_DIV_RUN   = 13'b0001000000000,
        ST_DIV_WR    = 13'b0010000000000,
        ST_OUT_RD    = 13'b0100000000000,
        ST_OUT_SEND  = 13'b1000000000000
    } state_t;

    state_t          state_reg, state_next;
    logic [3:0]      k_reg, k_next;
    logic [1:0]      t_reg, t_next;
    logic [1:0]      sub_reg, sub_next;
    logic            det_ph_reg, det_ph_next;
    logic [SW-1:0]   cnt_reg, cnt_next;

    logic [1:0]      r, c, ca, cb;
    logic [3:0]      addr_a, addr_b;

    always_comb
    begin
        r  = k_reg[3:2];
        c  = k_reg[1:0];
        ca = (t_reg == 2'd0) ? 2'd1 : 2'd0;
        cb = (t_reg == 2'd2) ? 2'd1 : 2'd2;
        addr_a = {skip_idx(c, ca), skip_idx(r, 2'd1)};
        addr_b = {skip_idx(c, cb), skip_idx(r, 2'd2)};
        if (det_ph_reg)
        begin
            addr_b = {2'd0, t_reg};
        end
        else if (sub_reg == 2'd1)
        begin
            addr_a = {skip_idx(c, cb), skip_idx(r, 2'd1)};
            addr_b = {skip_idx(c, ca), skip_idx(r, 2'd2)};
        end
        else if (sub_reg == 2'd2)
        begin
            addr_b = {skip_idx(c, t_reg), skip_idx(r, 2'd0)};
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        k_next      = k_reg;
        t_next      = t_reg;
        sub_next    = sub_reg;
        det_ph_next = det_ph_reg;
        cnt_next    = cnt_reg;

        cmd            = '0;
        cmd.mat_waddr  = k_reg;
        cmd.mat_raddr  = (state_reg == ST_FETCH_A) ? addr_a : addr_b;
        cmd.mc_sel     = det_ph_reg ? MC_COF : ((sub_reg == 2'd2) ? MC_M2 : MC_MAT);
        cmd.mul_last   = (cnt_reg == SW'(WORD_WIDTH - 1));
        cmd.acc_op     = ACC_NONE;
        cmd.cof_neg    = k_reg[2] ^ k_reg[0];
        cmd.cof_addr   = det_ph_reg ? {t_reg, 2'b00} : k_reg;
        cmd.res_addr   = k_reg;

        in_ready  = (state_reg == ST_LOAD);
        out_valid = (state_reg == ST_OUT_SEND);

        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    cmd.mat_we = 1'b1;
                    if (k_reg == LAST_INDEX)
                    begin
                        cmd.flag_clear = 1'b1;
                        k_next      = '0;
                        t_next      = '0;
                        sub_next    = '0;
                        det_ph_next = 1'b0;
                        state_next  = ST_FETCH_A;
                    end
                    else
                    begin
                        k_next = k_reg + 4'd1;
                    end
                end
            end
            ST_FETCH_A:
            begin
                state_next = ST_FETCH_B;
            end
            ST_FETCH_B:
            begin
                cmd.a_load = 1'b1;
                state_next = ST_MUL_START;
            end
            ST_MUL_START:
            begin
                cmd.mul_start = 1'b1;
                cnt_next      = '0;
                state_next    = ST_MUL_RUN;
            end
            ST_MUL_RUN:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + SW'(1);
                if (cmd.mul_last)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                state_next = ST_FETCH_A;
                if (det_ph_reg)
                begin
                    cmd.acc_op = (t_reg == 2'd0) ? ACC_DET_SET : ACC_DET_ADD;
                    t_next     = t_reg + 2'd1;
                    if (t_reg == 2'd3)
                    begin
                        det_ph_next = 1'b0;
                        k_next      = '0;
                        state_next  = ST_DIV_RD;
                    end
                end
                else
                begin
                    case (sub_reg)
                        2'd0:    cmd.acc_op = ACC_M2_SET;
                        2'd1:    cmd.acc_op = ACC_M2_SUB;
                        default:
                        begin
                            case (t_reg)
                                2'd0:    cmd.acc_op = ACC_COF_SET;
                                2'd1:    cmd.acc_op = ACC_COF_SUB;
                                default: cmd.acc_op = ACC_COF_ADD;
                            endcase
                        end
                    endcase
                    sub_next = sub_reg + 2'd1;
                    if (sub_reg == 2'd2)
                    begin
                        sub_next = '0;
                        t_next   = t_reg + 2'd1;
                        if (t_reg == 2'd2)
                        begin
                            t_next     = '0;
                            state_next = ST_COF_WR;
                        end
                    end
                end
            end
            ST_COF_WR:
            begin
                cmd.cof_we = 1'b1;
                state_next = ST_FETCH_A;
                k_next     = k_reg + 4'd1;
                if (k_reg == LAST_INDEX)
                begin
                    det_ph_next = 1'b1;
                    t_next      = '0;
                end
            end
            ST_DIV_RD:
            begin
                state_next = ST_DIV_INIT;
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = status.det_zero ? ST_DIV_WR : ST_DIV_RUN;
            end
            ST_DIV_RUN:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + SW'(1);
                if (cnt_reg == SW'(QW - 1))
                begin
                    state_next = ST_DIV_WR;
                end
            end
            ST_DIV_WR:
            begin
                cmd.res_we = 1'b1;
                k_next     = k_reg + 4'd1;
                state_next = (k_reg == LAST_INDEX) ? ST_OUT_RD : ST_DIV_RD;
            end
            ST_OUT_RD:
            begin
                state_next = ST_OUT_SEND;
            end
            ST_OUT_SEND:
            begin
                if (out_ready)
                begin
                    k_next     = k_reg + 4'd1;
                    state_next = (k_reg == LAST_INDEX) ? ST_LOAD : ST_OUT_RD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign out_index = k_reg;
    assign out_last  = (k_reg == LAST_INDEX);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            k_reg      <= '0;
            t_reg      <= '0;
            sub_reg    <= '0;
            det_ph_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            k_reg      <= k_next;
            t_reg      <= t_next;
            sub_reg    <= sub_next;
            det_ph_reg <= det_ph_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// File: rtl/matrix4_inverse_top.sv
// ----------------------------------------------------------------------------
// matrix4_inverse_top
// 4x4 fixed-point matrix inverse by cofactors and one rounded division each.
//
//   channel | dir | tdata (low bit up)                        | side band
//   s_axis  | in  | element_value                             | -
//   m_axis  | out | inverse_value, element_index              | tlast, tuser
//
// Sixteen words load one per cycle while s_tvalid stays high. Each cofactor
// takes 9 products on one serial multiplier, the determinant 4 more, and
// each of the sixteen words then gets one rounded division before the
// results are sent. No input is taken until the sixteenth result leaves.
// Reset returns to loading at position zero; output stalls hold the word.
// ----------------------------------------------------------------------------
module matrix4_inverse_top #(
    parameter int WORD_WIDTH = m4inv_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = m4inv_pkg::FRAC_BITS_DEF,
    localparam int IDW = ((WORD_WIDTH + 7) / 8) * 8,
    localparam int ODW = ((WORD_WIDTH + 4 + 7) / 8) * 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [IDW-1:0] s_tdata,   // element_value
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [ODW-1:0] m_tdata,   // inverse_value, element_index
    output logic           m_tlast,
    output logic           m_tuser    // singular_or_overflow
);
    import m4inv_pkg::*;

    m4inv_cmd_t            cmd;
    m4inv_status_t         status;
    logic [3:0]            out_index;
    logic [WORD_WIDTH-1:0] res_data;

    m4inv_ctrl #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (out_index),
        .out_last  (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    m4inv_dpath #(
        .WORD_WIDTH (WORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_tdata[WORD_WIDTH-1:0]),
        .status   (status),
        .res_data (res_data),
        .res_flag (m_tuser)
    );

    assign m_tdata = ODW'({out_index, res_data});

endmodule

// File: rtl/m4inv_checker.sv
// ----------------------------------------------------------------------------
// m4inv_checker
// Port-level checks for the matrix inverter, bound to the top level.
// ----------------------------------------------------------------------------
module m4inv_checker #(
    parameter int WORD_WIDTH = 32,
    parameter int ODW        = 40
) (
    input logic           clk,
    input logic           rst_n,
    input logic           s_tvalid,
    input logic           s_tready,
    input logic           m_tvalid,
    input logic           m_tready,
    input logic [ODW-1:0] m_tdata,
    input logic           m_tlast,
    input logic           m_tuser
);

    // stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed under stall");

    // no load while results are being delivered
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !m_tvalid)
        else $error("input taken during output phase");

    // run ends after the last word
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("output continued past last word");

    // last word carries index fifteen
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[WORD_WIDTH+3:WORD_WIDTH] == 4'd15)))
        else $error("tlast and element index disagree");

endmodule

bind matrix4_inverse_top m4inv_checker #(
    .WORD_WIDTH (WORD_WIDTH),
    .ODW        (ODW)
) u_m4inv_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// File: verif/tb_matrix4_inverse_top.sv
// ----------------------------------------------------------------------------
// tb_matrix4_inverse_top
// Streams 4x4 matrices into the inverter, predicts each inverse with exact
// wide-integer cofactor arithmetic and checks all sixteen result words.
// Runs identity-like, singular, saturating and fully random matrices under
// changing sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_matrix4_inverse_top;
    import m4inv_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int FRAC = FRAC_BITS_DEF;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  index;
        logic        last;
        logic        flag;
    } inv_word_t;

    class inverse_scoreboard;
        logic signed [31:0] elements[16];
        int                 load_pos;
        inv_word_t          expected_words[$];
        int                 errors;
        int                 words_seen;
        int                 flagged_runs;

        function new();
            load_pos = 0;
            errors = 0;
            words_seen = 0;
            flagged_runs = 0;
        endfunction

        function wide_t at(int row, int col);
            wide_t w;
            w = elements[col * 4 + row];
            return w;
        endfunction

        function wide_t cofactor(int row, int col);
            int    rs[3];
            int    cs[3];
            int    nr;
            int    nc;
            wide_t x[3][3];
            wide_t d;
            nr = 0;
            nc = 0;
            for (int i = 0; i < 4; i++)
            begin
                if (i != row) rs[nr++] = i;
                if (i != col) cs[nc++] = i;
            end
            for (int i = 0; i < 9; i++)
                x[i / 3][i % 3] = at(rs[i / 3], cs[i % 3]);
            d = x[0][0] * (x[1][1] * x[2][2] - x[1][2] * x[2][1])
              - x[0][1] * (x[1][0] * x[2][2] - x[1][2] * x[2][0])
              + x[0][2] * (x[1][0] * x[2][1] - x[1][1] * x[2][0]);
            return ((row + col) % 2 == 1) ? -d : d;
        endfunction

        // store one element; on the sixteenth, queue the whole inverse
        function void note_element(logic [31:0] v);
            wide_t       adj[16];
            wide_t       det;
            wide_t       num;
            logic [191:0] un, ud, uq, ur;
            logic        neg;
            logic        flag;
            logic [31:0] vals[16];
            inv_word_t   w;
            elements[load_pos] = v;
            if (load_pos != 15)
            begin
                load_pos++;
                return;
            end
            load_pos = 0;
            for (int k = 0; k < 16; k++) adj[k] = cofactor(k / 4, k % 4);
            det = 0;
            for (int k = 0; k < 4; k++) det = det + at(k, 0) * adj[k * 4];
            flag = 0;
            for (int k = 0; k < 16; k++)
            begin
                if (det == 0)
                begin
                    vals[k] = 0;
                    flag = 1;
                    continue;
                end
                num = adj[k] <<< (2 * FRAC);
                neg = (num < 0) != (det < 0);
                un = (num < 0) ? -num : num;
                ud = (det < 0) ? -det : det;
                uq = un / ud;
                ur = un % ud;
                if ((ur << 1) >= ud) uq = uq + 1;
                if (uq == 0) neg = 0;
                if (neg && uq > (192'd1 << 31))
                begin
                    uq = 192'd1 << 31;
                    flag = 1;
                end
                else if (!neg && uq > ((192'd1 << 31) - 1))
                begin
                    uq = (192'd1 << 31) - 1;
                    flag = 1;
                end
                vals[k] = neg ? -uq[31:0] : uq[31:0];
            end
            if (flag) flagged_runs++;
            for (int k = 0; k < 16; k++)
            begin
                w.value = vals[k];
                w.index = k[3:0];
                w.last  = (k[3:0] == LAST_INDEX);
                w.flag  = flag;
                expected_words.push_back(w);
            end
        endfunction

        function void check_word(logic [31:0] value, logic [3:0] index,
                                 logic last, logic flag);
            inv_word_t e;
            words_seen++;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: value %h index %0d", value, index);
                errors++;
                return;
            end
            e = expected_words.pop_front();
            if (value !== e.value)
            begin
                $error("inverse_value: expected %h, actual %h", e.value, value);
                errors++;
            end
            if (index !== e.index)
            begin
                $error("element_index: expected %0d, actual %0d", e.index, index);
                errors++;
            end
            if (last !== e.last)
            begin
                $error("last_element: expected %b, actual %b", e.last, last);
                errors++;
            end
            if (flag !== e.flag)
            begin
                $error("singular_or_overflow: expected %b, actual %b", e.flag, flag);
                errors++;
            end
        endfunction

        function int pending();
            return expected_words.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // element_value
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // inverse_value, element_index
    logic        m_tlast;
    logic        m_tuser;   // singular_or_overflow

    matrix4_inverse_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    inverse_scoreboard sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int matrices_sent = 0;
    logic [31:0] mat[16];

    initial clk = 0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: long hold-off at the start of the first random phase, otherwise random stalls
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 0;
        else if (hold_left > 0)
        begin
            m_tready <= 0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata[31:0], m_tdata[35:32], m_tlast, m_tuser);

    task send_element(input logic [31:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 0;
            @(negedge clk);
        end
        s_tvalid <= 1;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_element(v);
        @(negedge clk);
    endtask

    task send_matrix();
        for (int i = 0; i < 16; i++) send_element(mat[i]);
        matrices_sent++;
    endtask

    // kinds: full random, well-conditioned, tiny (saturates), singular, diagonal
    task make_random_matrix();
        int kind;
        kind = $urandom_range(4);
        for (int i = 0; i < 16; i++)
        begin
            case (kind)
                0: mat[i] = $urandom;
                1: mat[i] = (i % 5 == 0) ? 32'h0004_0000 + $urandom_range(65535)
                                         : $signed($urandom_range(131071)) - 65536;
                2: mat[i] = $signed($urandom_range(6)) - 3;
                3: mat[i] = $signed($urandom_range(1 << 20)) - (1 << 19);
                default: mat[i] = (i % 5 == 0) ? $urandom : 32'h0;
            endcase
        end
        if (kind == 3)
            for (int r = 0; r < 4; r++) mat[12 + r] = mat[r];
    endtask

    task drain();
        s_tvalid <= 0;
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n    = 0;
        s_tvalid = 0;
        s_tdata  = 0;
        m_tready = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // diagonal with unit and word extremes, then the zero matrix
        for (int i = 0; i < 16; i++) mat[i] = 32'h0;
        mat[0]  = 32'h0001_0000;
        mat[5]  = 32'hFFFF_0000;
        mat[10] = 32'h7FFF_FFFF;
        mat[15] = 32'h8000_0000;
        send_matrix();
        for (int i = 0; i < 16; i++) mat[i] = 32'h0;
        send_matrix();
        drain();

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            if (phase == 0) hold_left = 8000;
            for (int m = 0; m < 4; m++)
            begin
                make_random_matrix();
                send_matrix();
            end
            drain();
        end

        repeat (200) @(negedge clk);
        $display("covered %0d matrices, %0d result words, %0d singular or saturated",
                 matrices_sent, sb.words_seen, sb.flagged_runs);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: sim.f
rtl/m4inv_pkg.sv
rtl/m4inv_dpath.sv
rtl/m4inv_ctrl.sv
rtl/matrix4_inverse_top.sv
rtl/m4inv_checker.sv
verif/tb_matrix4_inverse_top.sv
